@@ hw/rtl/key_debounce_autorepeat_top_macros.svh @@
`ifndef KEY_DEBOUNCE_AUTOREPEAT_TOP_MACROS_SVH
`define KEY_DEBOUNCE_AUTOREPEAT_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define KDA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define KDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/kda_pkg.sv @@
package kda_pkg;

  localparam int KEYS      = 9;
  localparam int IN_W      = 9;
  localparam int KEY_W     = 4;
  localparam int IDX_W     = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int HIST_W    = 8;
  localparam int HOLD_W    = 16;
  localparam int PER_W     = 10;
  localparam int CFG_W     = 16;
  localparam int REG_IDX_W = 3;
  localparam int DIV_STEPS = HOLD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [HIST_W-1:0] PRESS_MASK_RST   = 8'h07;
  localparam logic [HIST_W-1:0] RELEASE_MASK_RST = 8'h07;
  localparam logic [HOLD_W-1:0] HOLD_THR_RST     = 16'd100;
  localparam logic [HOLD_W-1:0] TURBO_THR_RST    = 16'd240;
  localparam logic [PER_W-1:0]  SLOW_PER_RST     = 10'd40;
  localparam logic [PER_W-1:0]  TURBO_PER_RST    = 10'd8;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PRESS_MASK   = 3'd0,
    REG_RELEASE_MASK = 3'd1,
    REG_HOLD_THR     = 3'd2,
    REG_TURBO_THR    = 3'd3,
    REG_SLOW_PER     = 3'd4,
    REG_TURBO_PER    = 3'd5
  } reg_idx_t;

  typedef enum logic {
    EVT_KEY   = 1'b0,
    EVT_FLUSH = 1'b1
  } evt_kind_t;

  typedef struct packed {
    logic [HIST_W-1:0] make_mask;
    logic [HIST_W-1:0] break_mask;
    logic [HOLD_W-1:0] hold_threshold;
    logic [HOLD_W-1:0] turbo_threshold;
    logic [PER_W-1:0]  slow_repeat_period;
    logic [PER_W-1:0]  turbo_repeat_period;
  } cfg_t;

  typedef struct packed {
    logic      evt;
    evt_kind_t kind;
  } lane_res_t;

  typedef struct packed {
    logic busy;
  } merge_stat_t;

endpackage

@@ hw/rtl/kda_lane.sv @@
module kda_lane (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                step,
  input  logic                key_bit,
  input  kda_pkg::cfg_t       cfg,
  output kda_pkg::lane_res_t  res
);

  logic [kda_pkg::HIST_W-1:0] history;
  logic [kda_pkg::HOLD_W-1:0] hold_count;
  logic                       held;
  logic                       imm_evt;
  logic                       rep_cand;
  kda_pkg::evt_kind_t         kind;
  logic [kda_pkg::HOLD_W-1:0] dvd;
  logic [kda_pkg::PER_W-1:0]  rem;
  logic [kda_pkg::PER_W-1:0]  period;

  logic [kda_pkg::HIST_W-1:0] history_next;
  logic [kda_pkg::HOLD_W-1:0] count_next;
  logic [kda_pkg::PER_W-1:0]  per_sel;
  logic [kda_pkg::PER_W-1:0]  per_fix;
  logic [kda_pkg::PER_W:0]    trial;
  logic [kda_pkg::PER_W:0]    diff;
  logic                       fits;
  logic [kda_pkg::PER_W-1:0]  rem_next;

  assign history_next = {history[kda_pkg::HIST_W-2:0], key_bit};
  assign count_next   = hold_count + kda_pkg::HOLD_W'(1);
  assign per_sel      = (count_next > cfg.turbo_threshold) ? cfg.turbo_repeat_period
                                                          : cfg.slow_repeat_period;
  assign per_fix      = (per_sel == '0) ? kda_pkg::PER_W'(1) : per_sel;

  assign trial    = {rem, dvd[kda_pkg::HOLD_W-1]};
  assign fits     = trial >= {1'b0, period};
  assign diff     = trial - {1'b0, period};
  assign rem_next = fits ? diff[kda_pkg::PER_W-1:0] : trial[kda_pkg::PER_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      history    <= '0;
      hold_count <= '0;
      held       <= 1'b0;
      imm_evt    <= 1'b0;
      rep_cand   <= 1'b0;
    end else if (start) begin
      history  <= history_next;
      imm_evt  <= 1'b0;
      rep_cand <= 1'b0;
      rem      <= '0;
      kind     <= kda_pkg::EVT_KEY;
      if (!held) begin
        if ((history_next & cfg.make_mask) == cfg.make_mask) begin
          held       <= 1'b1;
          hold_count <= '0;
          imm_evt    <= 1'b1;
        end
      end else if ((history_next & cfg.break_mask) == '0) begin
        held       <= 1'b0;
        hold_count <= '0;
        imm_evt    <= 1'b1;
        kind       <= kda_pkg::EVT_FLUSH;
      end else begin
        hold_count <= count_next;
        rep_cand   <= count_next >= cfg.hold_threshold;
        dvd        <= count_next - cfg.hold_threshold;
        period     <= per_fix;
      end
    end else if (step) begin
      dvd <= {dvd[kda_pkg::HOLD_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign res.evt  = imm_evt | (rep_cand & (rem == '0));
  assign res.kind = kind;

endmodule

@@ hw/rtl/kda_merge.sv @@
module kda_merge (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  kda_pkg::lane_res_t        res [kda_pkg::KEYS],
  input  logic                      out_stall,
  output logic                      out_valid,
  output logic                      event_kind,
  output logic [kda_pkg::KEY_W-1:0] key_id,
  output logic                      last,
  output kda_pkg::merge_stat_t      stat
);

  logic [kda_pkg::KEYS-1:0]  pending;
  logic [kda_pkg::KEYS-1:0]  kinds;
  logic [kda_pkg::KEYS-1:0]  ev_vec;
  logic [kda_pkg::KEYS-1:0]  kind_vec;
  logic [kda_pkg::KEYS-1:0]  pick;
  logic [kda_pkg::KEYS-1:0]  remaining;
  logic [kda_pkg::IDX_W-1:0] pick_idx;
  logic                      advance;

  always_comb begin
    for (int i = 0; i < kda_pkg::KEYS; i++) begin
      ev_vec[i]   = res[i].evt;
      kind_vec[i] = (res[i].kind == kda_pkg::EVT_FLUSH);
    end
  end

  assign pick      = pending & (~pending + kda_pkg::KEYS'(1));
  assign remaining = pending & ~pick;
  assign advance   = (pending != '0) && (!out_valid || !out_stall);

  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < kda_pkg::KEYS; i++) begin
      if (pick[i]) begin
        pick_idx = pick_idx | kda_pkg::IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        pending <= ev_vec;
        kinds   <= kind_vec;
      end else if (advance) begin
        pending <= remaining;
      end
      if (advance) begin
        out_valid  <= 1'b1;
        event_kind <= |(pick & kinds);
        key_id     <= kda_pkg::KEY_W'(pick_idx);
        last       <= (remaining == '0);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.busy = |pending;

endmodule

@@ hw/rtl/key_debounce_autorepeat_top.sv @@
// Keypad debounce with typematic auto-repeat.
// Input channel (in_valid / in_stall, payload pressed_keys): one scan tick per
// transfer, one bit per key. Output channel (out_valid / out_stall, payload
// event_kind, key_id, last): the events caused by the tick in key order,
// last set on the final one. A tick that causes no event gives no transfer.
// Every key has its own lane; all lanes update in the accept cycle and then
// run a bit-serial remainder for the repeat timing, one bit per cycle over
// all 16 dividend bits. A load state then moves the lane results into the
// event queue, which issues one event per cycle while the receiver does not
// stall. in_stall stays high while a tick is processed and drops once the
// queue is empty, even while the final event still waits in the output
// register. A stall holds the output register and pauses the queue.
// Reset (rst, synchronous) clears all key histories, hold counters and hold
// flags, empties the queue and loads default register values. Registers are
// written through cfg_write / cfg_index / cfg_data; the user must write them
// only while the block is idle, as the block itself does not enforce it.
`include "key_debounce_autorepeat_top_macros.svh"

module key_debounce_autorepeat_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [kda_pkg::IN_W-1:0]      pressed_keys,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          event_kind,
  output logic [kda_pkg::KEY_W-1:0]     key_id,
  output logic                          last,
  input  logic                          cfg_write,
  input  logic [kda_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [kda_pkg::CFG_W-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DIVIDE = 4'b0010,
    ST_LOAD   = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  state_t                      state;
  state_t                      state_next;
  logic [kda_pkg::STEP_W-1:0]  step_cnt;
  kda_pkg::cfg_t               cfg;
  kda_pkg::lane_res_t          lane_res [kda_pkg::KEYS];
  kda_pkg::merge_stat_t        merge_stat;
  logic [kda_pkg::KEYS-1:0]    key_bits;
  logic                        accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.make_mask           <= kda_pkg::PRESS_MASK_RST;
      cfg.break_mask          <= kda_pkg::RELEASE_MASK_RST;
      cfg.hold_threshold      <= kda_pkg::HOLD_THR_RST;
      cfg.turbo_threshold     <= kda_pkg::TURBO_THR_RST;
      cfg.slow_repeat_period  <= kda_pkg::SLOW_PER_RST;
      cfg.turbo_repeat_period <= kda_pkg::TURBO_PER_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        kda_pkg::REG_PRESS_MASK:   cfg.make_mask <= cfg_data[kda_pkg::HIST_W-1:0];
        kda_pkg::REG_RELEASE_MASK: cfg.break_mask <= cfg_data[kda_pkg::HIST_W-1:0];
        kda_pkg::REG_HOLD_THR:     cfg.hold_threshold <= cfg_data[kda_pkg::HOLD_W-1:0];
        kda_pkg::REG_TURBO_THR:    cfg.turbo_threshold <= cfg_data[kda_pkg::HOLD_W-1:0];
        kda_pkg::REG_SLOW_PER:     cfg.slow_repeat_period <= cfg_data[kda_pkg::PER_W-1:0];
        kda_pkg::REG_TURBO_PER:    cfg.turbo_repeat_period <= cfg_data[kda_pkg::PER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (step_cnt == kda_pkg::STEP_W'(kda_pkg::DIV_STEPS - 1)) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!merge_stat.busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        step_cnt <= '0;
      end else if (state == ST_DIVIDE) begin
        step_cnt <= step_cnt + kda_pkg::STEP_W'(1);
      end
    end
  end

  for (genvar g = 0; g < kda_pkg::KEYS; g++) begin : g_lane
    if (g < kda_pkg::IN_W) begin : g_bit
      assign key_bits[g] = pressed_keys[g];
    end else begin : g_zero
      assign key_bits[g] = 1'b0;
    end

    kda_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .start   (accept),
      .step    (state == ST_DIVIDE),
      .key_bit (key_bits[g]),
      .cfg     (cfg),
      .res     (lane_res[g])
    );
  end

  kda_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .load       (state == ST_LOAD),
    .res        (lane_res),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .event_kind (event_kind),
    .key_id     (key_id),
    .last       (last),
    .stat       (merge_stat)
  );

  `KDA_ASSERT_NEXT(a_busy_after_accept, accept, in_stall, "input not stalled after a transfer")
  `KDA_ASSERT_SAME(a_queue_empty_on_accept, accept, !merge_stat.busy, "tick taken while events queued")
  `KDA_ASSERT_NEXT(a_hold_on_stall, out_valid && out_stall,
                   out_valid && $stable(event_kind) && $stable(key_id) && $stable(last),
                   "stalled output changed")

endmodule

@@ sim/testbench.sv @@
module testbench;
  import kda_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 32;
  localparam int MAX_REPORTS   = 10;
  localparam int SCANS_PER_SEG = 63;

  localparam logic [REG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam logic [IN_W-1:0] NO_KEYS   = '0;
  localparam logic [IN_W-1:0] ALL_KEYS  = '1;
  localparam logic [IN_W-1:0] EVEN_KEYS = 9'h155;
  localparam logic [IN_W-1:0] ODD_KEYS  = 9'h0AA;

  typedef struct {
    evt_kind_t        kind;
    logic [KEY_W-1:0] key;
    logic             last;
  } key_event_t;

  typedef struct {
    logic [REG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
  } reg_write_t;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic [IN_W-1:0]      pressed_keys = '0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic                 event_kind;
  logic [KEY_W-1:0]     key_id;
  logic                 last;
  logic                 cfg_write    = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]     cfg_data     = '0;

  key_debounce_autorepeat_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pressed_keys (pressed_keys),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_kind   (event_kind),
    .key_id       (key_id),
    .last         (last),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  logic [HIST_W-1:0] press_sel;
  logic [HIST_W-1:0] release_sel;
  logic [HOLD_W-1:0] repeat_start;
  logic [HOLD_W-1:0] turbo_start;
  logic [PER_W-1:0]  slow_period;
  logic [PER_W-1:0]  fast_period;

  logic [HIST_W-1:0] debounce_hist [KEYS];
  logic [HOLD_W-1:0] hold_ticks    [KEYS];
  logic              key_held      [KEYS];

  key_event_t  pending_events[$];
  reg_write_t  reg_writes[$];
  key_event_t  want;
  logic [IN_W-1:0] key_level = '0;

  int snd_idle_pct  = 0;
  int rcv_stall_pct = 0;
  int mismatches    = 0;
  int cycle_count   = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void reset_model();
    press_sel    = PRESS_MASK_RST;
    release_sel  = RELEASE_MASK_RST;
    repeat_start = HOLD_THR_RST;
    turbo_start  = TURBO_THR_RST;
    slow_period  = SLOW_PER_RST;
    fast_period  = TURBO_PER_RST;
    for (int k = 0; k < KEYS; k++) begin
      debounce_hist[k] = '0;
      hold_ticks[k]    = '0;
      key_held[k]      = 1'b0;
    end
  endfunction

  function automatic void apply_reg_write(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      REG_PRESS_MASK:   press_sel    = data[HIST_W-1:0];
      REG_RELEASE_MASK: release_sel  = data[HIST_W-1:0];
      REG_HOLD_THR:     repeat_start = data[HOLD_W-1:0];
      REG_TURBO_THR:    turbo_start  = data[HOLD_W-1:0];
      REG_SLOW_PER:     slow_period  = data[PER_W-1:0];
      REG_TURBO_PER:    fast_period  = data[PER_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void predict_scan_events(logic [IN_W-1:0] scan);
    key_event_t       tick_events [KEYS];
    int               n;
    logic [HIST_W-1:0] h;
    logic [HOLD_W-1:0] c;
    int unsigned      since;
    int unsigned      period;
    n = 0;
    for (int k = 0; k < KEYS; k++) begin
      h = {debounce_hist[k][HIST_W-2:0], scan[k]};
      debounce_hist[k] = h;
      tick_events[n].key  = KEY_W'(k);
      tick_events[n].last = 1'b0;
      tick_events[n].kind = EVT_KEY;
      if (!key_held[k]) begin
        if ((h & press_sel) == press_sel) begin
          key_held[k]   = 1'b1;
          hold_ticks[k] = '0;
          n++;
        end
      end else if ((h & release_sel) == '0) begin
        key_held[k]   = 1'b0;
        hold_ticks[k] = '0;
        tick_events[n].kind = EVT_FLUSH;
        n++;
      end else begin
        c = hold_ticks[k] + 1'b1;
        hold_ticks[k] = c;
        if (c >= repeat_start) begin
          since  = int'(c) - int'(repeat_start);
          period = (c > turbo_start) ? int'(fast_period) : int'(slow_period);
          if (period == 0) period = 1;
          if (since % period == 0) n++;
        end
      end
    end
    if (n > 0) tick_events[n-1].last = 1'b1;
    for (int e = 0; e < n; e++) pending_events.push_back(tick_events[e]);
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endfunction

  function automatic void queue_reg_write(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    reg_write_t w;
    w.idx  = idx;
    w.data = data;
    reg_writes.push_back(w);
  endfunction

  function automatic logic [IN_W-1:0] next_scan();
    logic [IN_W-1:0] scan;
    if ($urandom_range(9) == 0) return IN_W'($urandom);
    for (int k = 0; k < IN_W; k++) begin
      if ($urandom_range(99) < 8) key_level[k] = ~key_level[k];
      scan[k] = key_level[k] ^ ($urandom_range(99) < 5);
    end
    return scan;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        note_mismatch($sformatf("unexpected transfer kind %0d key %0d last %0d",
                                event_kind, key_id, last));
      end else begin
        want = pending_events.pop_front();
        if (event_kind !== want.kind || key_id !== want.key || last !== want.last)
          note_mismatch($sformatf("expected kind %0d key %0d last %0d, got kind %0d key %0d last %0d",
                                  want.kind, want.key, want.last, event_kind, key_id, last));
      end
    end
  end

  task automatic send_scan(logic [IN_W-1:0] scan);
    if (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid     <= 1'b1;
    pressed_keys <= scan;
    do @(posedge clk); while (in_stall);
    predict_scan_events(scan);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs();
    reg_write_t w;
    wait_drained();
    while (reg_writes.size() != 0) begin
      w = reg_writes.pop_front();
      cfg_write <= 1'b1;
      cfg_index <= w.idx;
      cfg_data  <= w.data;
      apply_reg_write(w.idx, w.data);
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic test_press_release();
    logic [IN_W-1:0] scans [11] = '{ALL_KEYS, ALL_KEYS, ALL_KEYS, EVEN_KEYS, EVEN_KEYS,
                                    NO_KEYS, NO_KEYS, NO_KEYS, ODD_KEYS, ODD_KEYS, ODD_KEYS};
    foreach (scans[i]) send_scan(scans[i]);
  endtask

  task automatic test_typematic();
    queue_reg_write(REG_PRESS_MASK, 16'h0001);
    queue_reg_write(REG_RELEASE_MASK, 16'h0001);
    queue_reg_write(REG_HOLD_THR, 16'd2);
    queue_reg_write(REG_TURBO_THR, 16'd4);
    queue_reg_write(REG_SLOW_PER, 16'd2);
    queue_reg_write(REG_TURBO_PER, 16'd1);
    program_regs();
    repeat (8) send_scan(ALL_KEYS);
    send_scan(NO_KEYS);
  endtask

  task automatic test_corner_regs();
    // zero masks toggle every key each tick; unused indexes must be ignored
    queue_reg_write(REG_PRESS_MASK, 16'hAB00);
    queue_reg_write(REG_RELEASE_MASK, 16'hCD00);
    queue_reg_write(REG_HOLD_THR, 16'd0);
    queue_reg_write(REG_TURBO_THR, 16'd0);
    queue_reg_write(REG_SLOW_PER, 16'hFC00);
    queue_reg_write(REG_TURBO_PER, 16'hFC00);
    queue_reg_write(REG_SPARE_6, 16'hFFFF);
    queue_reg_write(REG_SPARE_7, 16'hFFFF);
    program_regs();
    send_scan(ALL_KEYS);
    send_scan(NO_KEYS);
    send_scan(ALL_KEYS);
    // zero periods with zero threshold repeat on every held tick
    queue_reg_write(REG_RELEASE_MASK, 16'h00FF);
    queue_reg_write(REG_TURBO_THR, 16'd1);
    program_regs();
    repeat (3) send_scan(ALL_KEYS);
  endtask

  task automatic test_random();
    for (int seg = 0; seg < 8; seg++) begin
      case (seg / 2)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 81; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 81; end
        default: begin snd_idle_pct = 38; rcv_stall_pct = 38; end
      endcase
      if (seg == 0) begin
        queue_reg_write(REG_PRESS_MASK, 16'h0001);
        queue_reg_write(REG_RELEASE_MASK, 16'h0001);
        queue_reg_write(REG_HOLD_THR, 16'd1);
        queue_reg_write(REG_TURBO_THR, 16'd0);
        queue_reg_write(REG_SLOW_PER, 16'd1);
        queue_reg_write(REG_TURBO_PER, 16'd1);
      end else if (seg == 1) begin
        queue_reg_write(REG_PRESS_MASK, 16'h00FF);
        queue_reg_write(REG_RELEASE_MASK, 16'h00FF);
        queue_reg_write(REG_HOLD_THR, 16'hFFFF);
        queue_reg_write(REG_TURBO_THR, 16'hFFFF);
        queue_reg_write(REG_SLOW_PER, 16'd1023);
        queue_reg_write(REG_TURBO_PER, 16'd1023);
      end else begin
        queue_reg_write(REG_PRESS_MASK, {8'($urandom), 8'($urandom_range(255, 1))});
        queue_reg_write(REG_RELEASE_MASK, {8'($urandom), 8'($urandom_range(255, 1))});
        queue_reg_write(REG_HOLD_THR, 16'($urandom_range(12)));
        queue_reg_write(REG_TURBO_THR, 16'($urandom_range(24)));
        queue_reg_write(REG_SLOW_PER, {6'($urandom), 10'($urandom_range(6, 1))});
        queue_reg_write(REG_TURBO_PER, {6'($urandom), 10'($urandom_range(4, 1))});
      end
      program_regs();
      repeat (SCANS_PER_SEG) begin
        send_scan(next_scan());
        if ($urandom_range(39) == 0) wait_drained();
      end
    end
  endtask

  initial begin
    reset_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_press_release();
    test_typematic();
    test_corner_regs();
    test_random();
    wait_drained();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
